// ----- sv/assert_macros.svh -----
// Assertion macros shared by the engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define GBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define GBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GBA_ASSERT(lbl, prop, msg)
`define GBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/gba_pkg.sv -----
// Types and constants of the growable bit array engine.
package gba_pkg;

  localparam int CapacityBits = 1024;
  localparam int WordBits     = 64;
  localparam int BitIdxW      = $clog2(WordBits);
  localparam int NumWords     = CapacityBits / WordBits;
  localparam int WordAddrW    = $clog2(NumWords);
  localparam int IdxW         = $clog2(CapacityBits);
  localparam int CntW         = $clog2(CapacityBits + 1);
  localparam int AmtW         = 11;
  localparam int OpW          = 3;
  localparam int StatusW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_GROW_TO   = 3'd0,
    OP_ADD       = 3'd1,
    OP_SET       = 3'd2,
    OP_GET       = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_SWAP      = 3'd5,
    OP_SET_RANGE = 3'd6,
    OP_CLEAR     = 3'd7
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // Which bit position a memory access refers to.
  typedef enum logic [1:0] {
    POS_A     = 2'd0,
    POS_B     = 2'd1,
    POS_LAST  = 2'd2,
    POS_RANGE = 2'd3
  } pos_sel_e;

  // Source of the bit written by a single-bit write.
  typedef enum logic [1:0] {
    SRC_VAL  = 2'd0,
    SRC_TMP0 = 2'd1,
    SRC_TMP1 = 2'd2,
    SRC_ZERO = 2'd3
  } wr_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SET_WR,
    S_GET_CAP,
    S_REM_CAP,
    S_REM_WA,
    S_REM_RL,
    S_REM_WL,
    S_SW_CA,
    S_SW_WB,
    S_SW_RA,
    S_SW_WA,
    S_RG_RD,
    S_RG_WR,
    S_FIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     st_load;
    logic     rd_en;
    pos_sel_e rd_pos;
    logic     wr_en;
    pos_sel_e wr_pos;
    wr_src_e  wr_src;
    logic     wr_range;
    pos_sel_e cap_pos;
    logic     cap0;
    logic     cap1;
    logic     rb_cap;
    logic     cnt_grow;
    logic     cnt_dec;
    logic     clr_all;
    logic     rg_init;
    logic     rg_next;
    logic     res_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic a_ok;
    logic swap_ok;
    logic rng_ok;
    logic rng_empty;
    logic rg_last;
  } dp_stat_t;

endpackage

// ----- sv/gba_ctrl.sv -----
// Controller state machine that sequences each operation over the word store.
`include "assert_macros.svh"

module gba_ctrl import gba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Hold state and output flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.st_load = 1'b1;
        state_d       = S_FIN;
        case (stat_i.op)
          OP_GROW_TO, OP_ADD: cmd_o.cnt_grow = 1'b1;
          OP_CLEAR:           cmd_o.clr_all  = 1'b1;
          OP_SET: begin
            if (stat_i.a_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_pos = POS_A;
              state_d      = S_SET_WR;
            end
          end
          OP_GET: begin
            if (stat_i.a_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_pos = POS_A;
              state_d      = S_GET_CAP;
            end
          end
          OP_REMOVE: begin
            if (stat_i.a_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_pos = POS_LAST;
              state_d      = S_REM_CAP;
            end
          end
          OP_SWAP: begin
            if (stat_i.swap_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_pos = POS_A;
              state_d      = S_SW_CA;
            end
          end
          OP_SET_RANGE: begin
            if (stat_i.rng_ok && !stat_i.rng_empty) begin
              cmd_o.rg_init = 1'b1;
              state_d       = S_RG_RD;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_SET_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_pos = POS_A;
        cmd_o.wr_src = SRC_VAL;
        state_d      = S_FIN;
      end
      S_GET_CAP: begin
        cmd_o.rb_cap  = 1'b1;
        cmd_o.cap_pos = POS_A;
        state_d       = S_FIN;
      end
      // Move the last bit into the hole, then clear the last bit.
      S_REM_CAP: begin
        cmd_o.cap0    = 1'b1;
        cmd_o.cap_pos = POS_LAST;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pos  = POS_A;
        state_d       = S_REM_WA;
      end
      S_REM_WA: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_pos = POS_A;
        cmd_o.wr_src = SRC_TMP0;
        state_d      = S_REM_RL;
      end
      S_REM_RL: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_pos = POS_LAST;
        state_d      = S_REM_WL;
      end
      S_REM_WL: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_pos  = POS_LAST;
        cmd_o.wr_src  = SRC_ZERO;
        cmd_o.cnt_dec = 1'b1;
        state_d       = S_FIN;
      end
      // Swap: capture both bits, write B, reread A and write it.
      S_SW_CA: begin
        cmd_o.cap0    = 1'b1;
        cmd_o.cap_pos = POS_A;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_pos  = POS_B;
        state_d       = S_SW_WB;
      end
      S_SW_WB: begin
        cmd_o.cap1    = 1'b1;
        cmd_o.cap_pos = POS_B;
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_pos  = POS_B;
        cmd_o.wr_src  = SRC_TMP0;
        state_d       = S_SW_RA;
      end
      S_SW_RA: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_pos = POS_A;
        state_d      = S_SW_WA;
      end
      S_SW_WA: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_pos = POS_A;
        cmd_o.wr_src = SRC_TMP1;
        state_d      = S_FIN;
      end
      // Walk the words of the range, one read-modify-write each.
      S_RG_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_pos = POS_RANGE;
        state_d      = S_RG_WR;
      end
      S_RG_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_pos   = POS_RANGE;
        cmd_o.wr_range = 1'b1;
        if (stat_i.rg_last) begin
          state_d = S_FIN;
        end else begin
          cmd_o.rg_next = 1'b1;
          state_d       = S_RG_RD;
        end
      end
      // Hand the result over once the output register is free.
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `GBA_ASSERT(a_load_to_decode, cmd_o.load |=> state_q == S_DECODE, "accepted transaction not decoded")
  `GBA_ASSERT(a_no_rd_wr, !(cmd_o.rd_en && cmd_o.wr_en), "read and write issued together")
  `GBA_ASSERT(a_res_slot_free, cmd_o.res_load |-> !out_valid_q || out_ready_i, "result overwritten")

endmodule

// ----- sv/gba_dpath.sv -----
// Datapath: transaction registers, count, word store with valid bits and result register.
`include "assert_macros.svh"

module gba_dpath import gba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [IdxW-1:0]    index_a_i,
  input  logic [CntW-1:0]    index_b_i,
  input  logic [AmtW-1:0]    amount_i,
  input  logic               bit_value_i,
  output logic               read_bit_o,
  output logic [CntW-1:0]    live_count_o,
  output logic [StatusW-1:0] status_o
);

  // Transaction registers.
  op_e               op_q;
  logic [IdxW-1:0]   a_q;
  logic [CntW-1:0]   b_q;
  logic [AmtW-1:0]   amt_q;
  logic              val_q;

  // Architectural count and work registers.
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WordAddrW-1:0] wcnt_q;
  logic                 tmp0_q, tmp1_q, rb_q;
  status_e              st_q, st_d;

  // Result register.
  logic            res_rb_q;
  logic [CntW-1:0] res_cnt_q;
  status_e         res_st_q;

  // Word store.
  logic [WordBits-1:0] mem [NumWords];
  logic [NumWords-1:0] vld_q;
  logic [WordBits-1:0] rdata_q;
  logic                rvld_q;
  logic [WordBits-1:0] rword, wdata, mask;

  logic [CntW-1:0]      last_full, bm1_full;
  logic [IdxW-1:0]      last_idx, bm1_idx;
  logic [CntW:0]        target;
  logic                 full;
  logic [IdxW-1:0]      rd_pos_idx, wr_pos_idx, cap_pos_idx;
  logic [WordAddrW-1:0] rd_addr, wr_addr;
  logic [BitIdxW-1:0]   lo, hi;
  logic                 wbit, cap_bit;

  // Capture the input transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(op_i);
      a_q   <= index_a_i;
      b_q   <= index_b_i;
      amt_q <= amount_i;
      val_q <= bit_value_i;
    end
  end

  // Derived positions and checks.
  assign last_full = cnt_q - CntW'(1);
  assign last_idx  = last_full[IdxW-1:0];
  assign bm1_full  = b_q - CntW'(1);
  assign bm1_idx   = bm1_full[IdxW-1:0];
  assign target    = (op_q == OP_ADD) ? ({1'b0, cnt_q} + {1'b0, amt_q}) : {1'b0, amt_q};
  assign full      = target > (CntW+1)'(CapacityBits);

  assign stat_o.op        = op_q;
  assign stat_o.a_ok      = {1'b0, a_q} < cnt_q;
  assign stat_o.swap_ok   = ({1'b0, a_q} < cnt_q) && (b_q < cnt_q);
  assign stat_o.rng_ok    = ({1'b0, a_q} < cnt_q) && (b_q <= cnt_q) && ({1'b0, a_q} <= b_q);
  assign stat_o.rng_empty = {1'b0, a_q} == b_q;
  assign stat_o.rg_last   = wcnt_q == bm1_idx[IdxW-1:BitIdxW];

  function automatic logic [IdxW-1:0] pick_pos(pos_sel_e sel, logic [IdxW-1:0] a,
                                               logic [IdxW-1:0] b, logic [IdxW-1:0] last);
    logic [IdxW-1:0] p;
    case (sel)
      POS_A:    p = a;
      POS_B:    p = b;
      POS_LAST: p = last;
      default:  p = a;
    endcase
    return p;
  endfunction

  assign rd_pos_idx  = pick_pos(cmd_i.rd_pos, a_q, b_q[IdxW-1:0], last_idx);
  assign wr_pos_idx  = pick_pos(cmd_i.wr_pos, a_q, b_q[IdxW-1:0], last_idx);
  assign cap_pos_idx = pick_pos(cmd_i.cap_pos, a_q, b_q[IdxW-1:0], last_idx);
  assign rd_addr = (cmd_i.rd_pos == POS_RANGE) ? wcnt_q : rd_pos_idx[IdxW-1:BitIdxW];
  assign wr_addr = (cmd_i.wr_pos == POS_RANGE) ? wcnt_q : wr_pos_idx[IdxW-1:BitIdxW];

  // Words never written since reset or clear read as zero.
  assign rword   = rvld_q ? rdata_q : '0;
  assign cap_bit = rword[cap_pos_idx[BitIdxW-1:0]];

  // Range mask of the current word.
  assign lo = (wcnt_q == a_q[IdxW-1:BitIdxW]) ? a_q[BitIdxW-1:0] : '0;
  assign hi = stat_o.rg_last ? bm1_idx[BitIdxW-1:0] : '1;
  always_comb begin
    for (int j = 0; j < WordBits; j++) begin
      mask[j] = (BitIdxW'(j) >= lo) && (BitIdxW'(j) <= hi);
    end
  end

  // Build the write word from the word just read.
  always_comb begin
    case (cmd_i.wr_src)
      SRC_VAL:  wbit = val_q;
      SRC_TMP0: wbit = tmp0_q;
      SRC_TMP1: wbit = tmp1_q;
      default:  wbit = 1'b0;
    endcase
    wdata = rword;
    if (cmd_i.wr_range) begin
      wdata = (rword & ~mask) | (val_q ? mask : '0);
    end else begin
      wdata[wr_pos_idx[BitIdxW-1:0]] = wbit;
    end
  end

  // Store array, registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Per-word valid bits and the registered valid of the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_all) begin
        vld_q <= '0;
      end else if (cmd_i.wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
    end
  end

  // Count update.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_all) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_grow) begin
      if (full) begin
        cnt_d = CntW'(CapacityBits);
      end else if (target[CntW-1:0] > cnt_q) begin
        cnt_d = target[CntW-1:0];
      end
    end else if (cmd_i.cnt_dec) begin
      cnt_d = last_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Status of the current transaction.
  always_comb begin
    case (op_q)
      OP_GROW_TO, OP_ADD:         st_d = full ? ST_FULL : ST_OK;
      OP_SET, OP_GET, OP_REMOVE: st_d = stat_o.a_ok ? ST_OK : ST_BAD_INDEX;
      OP_SWAP:                    st_d = stat_o.swap_ok ? ST_OK : ST_BAD_INDEX;
      OP_SET_RANGE:               st_d = stat_o.rng_ok ? ST_OK : ST_BAD_INDEX;
      default:                    st_d = ST_OK;
    endcase
  end

  // Work registers: status, captured bits, range word counter.
  always_ff @(posedge clk_i) begin
    if (cmd_i.st_load) begin
      st_q <= st_d;
    end
    if (cmd_i.load) begin
      rb_q <= 1'b0;
    end else if (cmd_i.rb_cap) begin
      rb_q <= cap_bit;
    end
    if (cmd_i.cap0) begin
      tmp0_q <= cap_bit;
    end
    if (cmd_i.cap1) begin
      tmp1_q <= cap_bit;
    end
    if (cmd_i.rg_init) begin
      wcnt_q <= a_q[IdxW-1:BitIdxW];
    end else if (cmd_i.rg_next) begin
      wcnt_q <= wcnt_q + WordAddrW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_rb_q  <= rb_q;
      res_cnt_q <= cnt_q;
      res_st_q  <= st_q;
    end
  end

  assign read_bit_o   = res_rb_q;
  assign live_count_o = res_cnt_q;
  assign status_o     = res_st_q;

  `GBA_ASSERT(a_cnt_cap, cnt_q <= CntW'(CapacityBits), "count above capacity")
  `GBA_ASSERT(a_clr_zero, cmd_i.clr_all |=> cnt_q == '0 && vld_q == '0, "clear left state behind")
  `GBA_ASSERT(a_rmw_addr, cmd_i.wr_en |-> $past(cmd_i.rd_en) && wr_addr == $past(rd_addr), "write without read of same word")

endmodule

// ----- sv/growable_bit_array_engine.sv -----
// Growable bit array engine: controller and datapath around a 16 x 64-bit word store.
//
// A 1024-bit array with a live element count. Each accepted transaction performs one
// operation and returns one result (bit read, count after the operation, status). An
// item occupies the engine from acceptance until its result enters the output register.
// Grow, add, clear, an empty range and any rejected item touch no word. In the word
// store, which is never read and written together, each written bit costs a registered
// read and a write (get only reads), and a range walks its words one read-modify-write
// at a time. The next transaction is taken while a finished result waits in the output
// register. Reset and clear zero the count and the per-word valid bits, which make
// unwritten words read as zero.
module growable_bit_array_engine import gba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [IdxW-1:0]    index_a_i,
  input  logic [CntW-1:0]    index_b_i,
  input  logic [AmtW-1:0]    amount_i,
  input  logic               bit_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               read_bit_o,
  output logic [CntW-1:0]    live_count_o,
  output logic [StatusW-1:0] status_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gba_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .index_a_i    (index_a_i),
    .index_b_i    (index_b_i),
    .amount_i     (amount_i),
    .bit_value_i  (bit_value_i),
    .read_bit_o   (read_bit_o),
    .live_count_o (live_count_o),
    .status_o     (status_o)
  );

endmodule
